// ===== hdl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_DESTROY  = 3'd1;
  localparam logic [2:0] CMD_DEFER    = 3'd2;
  localparam logic [2:0] CMD_FLUSH    = 3'd3;
  localparam logic [2:0] CMD_QUERY    = 3'd4;

  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_DESTROYED = 3'd1;
  localparam logic [2:0] ST_NOT_ALIVE = 3'd2;
  localparam logic [2:0] ST_QUEUED    = 3'd3;
  localparam logic [2:0] ST_QFULL     = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED = 3'd5;
  localparam logic [2:0] ST_SKIPPED   = 3'd6;
  localparam logic [2:0] ST_NONE      = 3'd7;

  localparam logic [23:0] INVALID_INDEX   = 24'hFFFFFF;
  localparam logic [7:0]  INVALID_VERSION = 8'hFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [23:0] entity_index;
    logic [7:0]  entity_version;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_alive;
    logic [23:0] result_index;
    logic [7:0]  result_version;
    logic [10:0] live_count;
    logic [10:0] high_water;
    logic        last;
  } result_t;

endpackage

// ===== hdl/gha_ram.sv =====
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot allocator with 8-bit generations, FIFO free list and deferred destroy.
// ----------------------------------------------------------------------------
//  channel   signals                 handshake
//  request   start, busy, request    beat taken when start && !busy
//  result    done, result            one-cycle strobe, no back-pressure
//
//  Create from the free list: free FIFO read, slot RAM read, then slot write.
//  Create of a fresh slot or exhaustion, flush of an empty queue: from idle.
//  Destroy, deferred destroy, query: slot RAM read, then update.
//  Flush: per pending entry, pending RAM read, then slot RAM read and update.
//  Reset clears no RAM: unwritten slot entries may be read, but live needs
//  the index below the high-water mark. Results cannot stall.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
  parameter int MAX_SLOTS     = 1024,
  parameter int PENDING_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  gha_pkg::request_t  request,
  output logic               done,
  output gha_pkg::result_t   result
);

  localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int PEW = SW + 8;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FREE  = 6'b000010,
    S_CRGEN = 6'b000100,
    S_CHECK = 6'b001000,
    S_FLRD  = 6'b010000,
    S_FLCHK = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [2:0]       cmd_q, cmd_q_next;
  logic [23:0]      idx_q, idx_q_next;
  logic [7:0]       ver_q, ver_q_next;
  logic [SW-1:0]    slot_q, slot_q_next;
  logic [SW-1:0]    free_head, free_head_next;
  logic [SW-1:0]    free_tail, free_tail_next;
  logic [CW-1:0]    free_count, free_count_next;
  logic [CW-1:0]    slots_used, slots_used_next;
  logic [CW-1:0]    live_total, live_total_next;
  logic [PCW-1:0]   pend_count, pend_count_next;
  logic [PCW-1:0]   flush_ptr, flush_ptr_next;
  logic             done_next;
  gha_pkg::result_t result_next;

  logic             slot_we;
  logic [SW-1:0]    slot_waddr, slot_raddr;
  logic [8:0]       slot_wdata, slot_rdata;
  logic             fifo_we;
  logic [SW-1:0]    fifo_rdata;
  logic             pend_we;
  logic [PW-1:0]    pend_waddr, pend_raddr;
  logic [PEW-1:0]   pend_wdata, pend_rdata;

  logic             live;
  logic [PCW-1:0]   flush_ptr_inc;

  // slot RAM: {alive, generation}
  gha_ram #(.WIDTH(9), .DEPTH(MAX_SLOTS), .AW(SW)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  gha_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS), .AW(SW)) u_free_fifo (
    .clk(clk), .we(fifo_we), .waddr(free_tail), .wdata(idx_q[SW-1:0]),
    .raddr(free_head), .rdata(fifo_rdata)
  );

  gha_ram #(.WIDTH(PEW), .DEPTH(PENDING_DEPTH), .AW(PW)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rdata)
  );

  assign busy          = (state != S_IDLE);
  assign flush_ptr_inc = flush_ptr + PCW'(1);

  assign live = !(idx_q == gha_pkg::INVALID_INDEX && ver_q == gha_pkg::INVALID_VERSION)
                && (idx_q < 24'(slots_used))
                && slot_rdata[8] && (slot_rdata[7:0] == ver_q);

  assign pend_waddr = pend_count[PW-1:0];
  assign pend_wdata = {idx_q[SW-1:0], ver_q};

  always_comb begin
    state_next       = state;
    cmd_q_next       = cmd_q;
    idx_q_next       = idx_q;
    ver_q_next       = ver_q;
    slot_q_next      = slot_q;
    free_head_next   = free_head;
    free_tail_next   = free_tail;
    free_count_next  = free_count;
    slots_used_next  = slots_used;
    live_total_next  = live_total;
    pend_count_next  = pend_count;
    flush_ptr_next   = flush_ptr;
    done_next        = 1'b0;
    result_next      = result;
    slot_we          = 1'b0;
    slot_waddr       = idx_q[SW-1:0];
    slot_wdata       = {1'b0, slot_rdata[7:0] + 8'd1};
    slot_raddr       = idx_q[SW-1:0];
    fifo_we          = 1'b0;
    pend_we          = 1'b0;
    pend_raddr       = flush_ptr[PW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next     = request.command;
          idx_q_next     = request.entity_index;
          ver_q_next     = request.entity_version;
          flush_ptr_next = '0;
          pend_raddr     = '0;
          case (request.command)
            gha_pkg::CMD_CREATE: begin
              if (free_count != '0) begin
                state_next = S_FREE;
              end else if (slots_used != CW'(MAX_SLOTS)) begin
                slot_we         = 1'b1;
                slot_waddr      = slots_used[SW-1:0];
                slot_wdata      = 9'h100;
                slots_used_next = slots_used + CW'(1);
                live_total_next = live_total + CW'(1);
                done_next       = 1'b1;
                result_next     = '{gha_pkg::ST_CREATED, 1'b0, 24'(slots_used), 8'd0,
                                    11'(live_total_next), 11'(slots_used_next), 1'b1};
              end else begin
                done_next   = 1'b1;
                result_next = '{gha_pkg::ST_EXHAUSTED, 1'b0, 24'd0, 8'd0,
                                11'(live_total), 11'(slots_used), 1'b1};
              end
            end
            gha_pkg::CMD_DESTROY, gha_pkg::CMD_DEFER, gha_pkg::CMD_QUERY: begin
              slot_raddr = request.entity_index[SW-1:0];
              state_next = S_CHECK;
            end
            gha_pkg::CMD_FLUSH: begin
              if (pend_count == '0) begin
                done_next   = 1'b1;
                result_next = '{gha_pkg::ST_NONE, 1'b0, 24'd0, 8'd0,
                                11'(live_total), 11'(slots_used), 1'b1};
              end else begin
                state_next = S_FLRD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FREE: begin
        // head entry is out of the FIFO RAM
        slot_q_next    = fifo_rdata;
        slot_raddr     = fifo_rdata;
        free_head_next = (free_head == SW'(MAX_SLOTS - 1)) ? '0 : free_head + SW'(1);
        free_count_next = free_count - CW'(1);
        state_next     = S_CRGEN;
      end

      S_CRGEN: begin
        slot_we         = 1'b1;
        slot_waddr      = slot_q;
        slot_wdata      = {1'b1, slot_rdata[7:0]};
        live_total_next = live_total + CW'(1);
        done_next       = 1'b1;
        result_next     = '{gha_pkg::ST_CREATED, 1'b0, 24'(slot_q), slot_rdata[7:0],
                            11'(live_total_next), 11'(slots_used), 1'b1};
        state_next      = S_IDLE;
      end

      S_CHECK: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        result_next = '{gha_pkg::ST_NOT_ALIVE, live, idx_q, ver_q,
                        11'(live_total), 11'(slots_used), 1'b1};
        case (cmd_q)
          gha_pkg::CMD_DESTROY: begin
            if (live) begin
              slot_we         = 1'b1;
              fifo_we         = 1'b1;
              free_tail_next  = (free_tail == SW'(MAX_SLOTS - 1)) ? '0 : free_tail + SW'(1);
              free_count_next = free_count + CW'(1);
              live_total_next = live_total - CW'(1);
              result_next.status     = gha_pkg::ST_DESTROYED;
              result_next.live_count = 11'(live_total_next);
            end
          end
          gha_pkg::CMD_DEFER: begin
            if (live) begin
              if (pend_count == PCW'(PENDING_DEPTH)) begin
                result_next.status = gha_pkg::ST_QFULL;
              end else begin
                pend_we            = 1'b1;
                pend_count_next    = pend_count + PCW'(1);
                result_next.status = gha_pkg::ST_QUEUED;
              end
            end
          end
          default: begin
            if (live) begin
              result_next.status = gha_pkg::ST_CREATED;
            end
          end
        endcase
      end

      S_FLRD: begin
        idx_q_next = 24'(pend_rdata[PEW-1:8]);
        ver_q_next = pend_rdata[7:0];
        slot_raddr = pend_rdata[PEW-1:8];
        state_next = S_FLCHK;
      end

      S_FLCHK: begin
        done_next   = 1'b1;
        result_next = '{gha_pkg::ST_SKIPPED, live, idx_q, ver_q,
                        11'(live_total), 11'(slots_used), 1'b0};
        if (live) begin
          slot_we         = 1'b1;
          fifo_we         = 1'b1;
          free_tail_next  = (free_tail == SW'(MAX_SLOTS - 1)) ? '0 : free_tail + SW'(1);
          free_count_next = free_count + CW'(1);
          live_total_next = live_total - CW'(1);
          result_next.status     = gha_pkg::ST_DESTROYED;
          result_next.live_count = 11'(live_total_next);
        end
        flush_ptr_next = flush_ptr_inc;
        pend_raddr     = flush_ptr_inc[PW-1:0];
        if (flush_ptr_inc == pend_count) begin
          result_next.last = 1'b1;
          pend_count_next  = '0;
          state_next       = S_IDLE;
        end else begin
          state_next = S_FLRD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= '0;
      free_tail  <= '0;
      free_count <= '0;
      slots_used <= '0;
      live_total <= '0;
      pend_count <= '0;
      flush_ptr  <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      free_head  <= free_head_next;
      free_tail  <= free_tail_next;
      free_count <= free_count_next;
      slots_used <= slots_used_next;
      live_total <= live_total_next;
      pend_count <= pend_count_next;
      flush_ptr  <= flush_ptr_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q  <= cmd_q_next;
    idx_q  <= idx_q_next;
    ver_q  <= ver_q_next;
    slot_q <= slot_q_next;
    result <= result_next;
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational handle allocator: directed cases,
// a pending queue overflow, then random command streams under several sender
// idle rates. A local model predicts every result beat; a monitor checks them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS      = 1024;
  localparam int PEND_DEPTH = 16;
  localparam int CYCLE_CAP  = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  gha_pkg::request_t request = '0;
  logic              done;
  gha_pkg::result_t  result;

  always #5 clk = ~clk;

  generational_handle_allocator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  // model state
  logic [7:0]  gen_tbl [SLOTS];
  logic        alive_tbl [SLOTS];
  logic [9:0]  free_list [SLOTS];
  int          free_rd, free_wr, free_cnt, used_cnt, live_cnt;
  logic [23:0] pend_idx [PEND_DEPTH];
  logic [7:0]  pend_ver [PEND_DEPTH];
  int          pend_cnt;

  gha_pkg::result_t expected_results[$];
  int          idle_pct = 0;
  int          errors = 0;
  int          beats_checked = 0;
  int          items_sent = 0;
  int          cycles = 0;

  function automatic bit is_live(logic [23:0] idx, logic [7:0] ver);
    if (idx == gha_pkg::INVALID_INDEX && ver == gha_pkg::INVALID_VERSION) return 1'b0;
    if (idx >= used_cnt) return 1'b0;
    return alive_tbl[idx] && gen_tbl[idx] == ver;
  endfunction

  function automatic void retire_slot(logic [23:0] idx);
    alive_tbl[idx] = 1'b0;
    gen_tbl[idx] = gen_tbl[idx] + 8'd1;
    free_list[free_wr] = idx[9:0];
    free_wr = (free_wr + 1) % SLOTS;
    free_cnt++;
    live_cnt--;
  endfunction

  function automatic void push_result(logic [2:0] st, bit alv, logic [23:0] idx,
                                      logic [7:0] ver, bit lst);
    gha_pkg::result_t r;
    r.status = st;
    r.is_alive = alv;
    r.result_index = idx;
    r.result_version = ver;
    r.live_count = live_cnt[10:0];
    r.high_water = used_cnt[10:0];
    r.last = lst;
    expected_results = {expected_results, r};
  endfunction

  function automatic void predict_allocator(gha_pkg::request_t rq);
    int  slot;
    bit  alv;
    case (rq.command)
      gha_pkg::CMD_CREATE: begin
        if (free_cnt > 0) begin
          slot = free_list[free_rd];
          free_rd = (free_rd + 1) % SLOTS;
          free_cnt--;
        end else if (used_cnt < SLOTS) begin
          slot = used_cnt;
          gen_tbl[slot] = 8'd0;
          used_cnt++;
        end else begin
          push_result(gha_pkg::ST_EXHAUSTED, 1'b0, '0, '0, 1'b1);
          return;
        end
        alive_tbl[slot] = 1'b1;
        live_cnt++;
        push_result(gha_pkg::ST_CREATED, 1'b0, slot[23:0], gen_tbl[slot], 1'b1);
      end
      gha_pkg::CMD_DESTROY: begin
        alv = is_live(rq.entity_index, rq.entity_version);
        if (alv) retire_slot(rq.entity_index);
        push_result(alv ? gha_pkg::ST_DESTROYED : gha_pkg::ST_NOT_ALIVE, alv,
                    rq.entity_index, rq.entity_version, 1'b1);
      end
      gha_pkg::CMD_DEFER: begin
        alv = is_live(rq.entity_index, rq.entity_version);
        if (!alv) begin
          push_result(gha_pkg::ST_NOT_ALIVE, 1'b0, rq.entity_index, rq.entity_version,
                      1'b1);
        end else if (pend_cnt >= PEND_DEPTH) begin
          push_result(gha_pkg::ST_QFULL, 1'b1, rq.entity_index, rq.entity_version, 1'b1);
        end else begin
          pend_idx[pend_cnt] = rq.entity_index;
          pend_ver[pend_cnt] = rq.entity_version;
          pend_cnt++;
          push_result(gha_pkg::ST_QUEUED, 1'b1, rq.entity_index, rq.entity_version, 1'b1);
        end
      end
      gha_pkg::CMD_FLUSH: begin
        if (pend_cnt == 0) begin
          push_result(gha_pkg::ST_NONE, 1'b0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < pend_cnt; i++) begin
            alv = is_live(pend_idx[i], pend_ver[i]);
            if (alv) retire_slot(pend_idx[i]);
            push_result(alv ? gha_pkg::ST_DESTROYED : gha_pkg::ST_SKIPPED, alv,
                        pend_idx[i], pend_ver[i], i == pend_cnt - 1);
          end
          pend_cnt = 0;
        end
      end
      gha_pkg::CMD_QUERY: begin
        alv = is_live(rq.entity_index, rq.entity_version);
        push_result(alv ? gha_pkg::ST_CREATED : gha_pkg::ST_NOT_ALIVE, alv,
                    rq.entity_index, rq.entity_version, 1'b1);
      end
      default: ;  // undefined codes are dropped
    endcase
  endfunction

  // one request beat: optional idle gap, then hold start until taken
  task automatic send_request(logic [2:0] cmd, logic [23:0] idx, logic [7:0] ver);
    gha_pkg::request_t rq;
    int gap;
    rq.command = cmd;
    rq.entity_index = idx;
    rq.entity_version = ver;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_allocator(rq);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // handle of a random used slot: mostly current generation, sometimes stale; now and then an invalid or random handle
  task automatic pick_handle(output logic [23:0] idx, output logic [7:0] ver);
    int s;
    if (used_cnt == 0 || $urandom_range(99) < 6) begin
      idx = $urandom_range(1) ? gha_pkg::INVALID_INDEX : 24'($urandom);
      ver = $urandom_range(1) ? gha_pkg::INVALID_VERSION : 8'($urandom);
      return;
    end
    s = $urandom_range(used_cnt - 1);
    idx = s[23:0];
    case ($urandom_range(9))
      0: ver = 8'($urandom);
      1: ver = gen_tbl[s] - 8'd1;
      default: ver = gen_tbl[s];
    endcase
  endtask

  // result monitor
  always @(posedge clk) begin
    gha_pkg::result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %p", $time, result);
        errors++;
      end else begin
        want = expected_results.pop_front();
        beats_checked++;
        if (result.status !== want.status || result.is_alive !== want.is_alive ||
            result.result_index !== want.result_index ||
            result.result_version !== want.result_version ||
            result.live_count !== want.live_count ||
            result.high_water !== want.high_water || result.last !== want.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, result);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // empty system: flush, invalid handle, out-of-range index
    send_request(gha_pkg::CMD_FLUSH, '0, '0);
    send_request(gha_pkg::CMD_QUERY, gha_pkg::INVALID_INDEX, gha_pkg::INVALID_VERSION);
    send_request(gha_pkg::CMD_DESTROY, 24'd0, 8'd0);
    send_request(gha_pkg::CMD_CREATE, '0, '0);
    send_request(gha_pkg::CMD_CREATE, '0, '0);
    send_request(gha_pkg::CMD_QUERY, 24'd1, 8'd0);
    send_request(gha_pkg::CMD_QUERY, 24'd1, 8'd1);
    send_request(gha_pkg::CMD_QUERY, 24'h800000, 8'h80);
    send_request(3'd5, 24'd0, 8'd0);
    send_request(3'd7, gha_pkg::INVALID_INDEX, gha_pkg::INVALID_VERSION);
    // destroy, destroy again, reuse with bumped generation
    send_request(gha_pkg::CMD_DESTROY, 24'd0, 8'd0);
    send_request(gha_pkg::CMD_DESTROY, 24'd0, 8'd0);
    send_request(gha_pkg::CMD_CREATE, '0, '0);
    send_request(gha_pkg::CMD_QUERY, 24'd0, 8'd1);
    // same handle deferred twice: second entry skipped at flush
    send_request(gha_pkg::CMD_DEFER, 24'd1, 8'd0);
    send_request(gha_pkg::CMD_DEFER, 24'd1, 8'd0);
    send_request(gha_pkg::CMD_DEFER, 24'd5, 8'd0);
    send_request(gha_pkg::CMD_FLUSH, '0, '0);
    send_request(3'd6, 24'd3, 8'd3);
    drain_results();
  endtask

  task automatic test_queue_full();
    repeat (18) send_request(gha_pkg::CMD_CREATE, '0, '0);
    for (int s = 0; s < used_cnt && pend_cnt < PEND_DEPTH + 1; s++)
      if (alive_tbl[s]) send_request(gha_pkg::CMD_DEFER, s[23:0], gen_tbl[s]);
    send_request(gha_pkg::CMD_FLUSH, '0, '0);
    drain_results();
  endtask

  task automatic test_random(int n);
    logic [23:0] idx;
    logic [7:0]  ver;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      pick_handle(idx, ver);
      if (pick < 30 && used_cnt < SLOTS - 32) send_request(gha_pkg::CMD_CREATE, idx, ver);
      else if (pick < 50) send_request(gha_pkg::CMD_DESTROY, idx, ver);
      else if (pick < 72) send_request(gha_pkg::CMD_DEFER, idx, ver);
      else if (pick < 80) send_request(gha_pkg::CMD_FLUSH, idx, ver);
      else if (pick < 97) send_request(gha_pkg::CMD_QUERY, idx, ver);
      else send_request(3'($urandom_range(7, 5)), idx, ver);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_queue_full();
    idle_pct = 0;
    test_random(100);
    idle_pct = 69;
    test_random(110);
    drain_results();  // sender holds off until everything is back
    idle_pct = 36;
    test_random(110);
    idle_pct = 0;
    test_random(100);
    drain_results();
    $display("Covered %0d requests and %0d result beats across idle rates 0/69/36,",
             items_sent, beats_checked);
    $display("final high-water mark %0d, %0d live handles.", used_cnt, live_cnt);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/gha_pkg.sv
hdl/gha_ram.sv
hdl/generational_handle_allocator.sv
bench/tb_top.sv
